@@ sv/lawtex_pkg.sv @@
// Shared types, constants and helper functions of the Laws texture mask filter.
`default_nettype none
package lawtex_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int RESP_W        = 20;
  localparam int CFG_W         = 11;
  localparam int SEL_W         = 3;
  localparam int TAPS          = 5;
  localparam int LINE_CELLS    = TAPS - 1;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int HGT_W         = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W         = $clog2(MAX_HEIGHT);
  localparam int KROW_W        = $clog2(MAX_HEIGHT + 3);
  localparam int VSUM_W        = 17;
  localparam int HSUM_W        = 21;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1024);

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_VSEL   = 2'd0;
  localparam cfg_idx_t CFG_HSEL   = 2'd1;
  localparam cfg_idx_t CFG_WIDTH  = 2'd2;
  localparam cfg_idx_t CFG_HEIGHT = 2'd3;

  typedef logic [SEL_W-1:0] vec_sel_t;
  localparam vec_sel_t VEC_L5 = 3'd0;
  localparam vec_sel_t VEC_E5 = 3'd1;
  localparam vec_sel_t VEC_S5 = 3'd2;
  localparam vec_sel_t VEC_W5 = 3'd3;
  localparam vec_sel_t VEC_R5 = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RESP_W-1:0]   resp_t;
  typedef logic signed [3:0]          coef_t;
  typedef logic signed [VSUM_W-1:0]   vsum_t;
  typedef logic signed [HSUM_W-1:0]   hsum_t;
  typedef sample_t [TAPS-1:0]         column_t;

  // Per-pixel control that travels down the pipeline with its column.
  typedef struct packed {
    logic emit;
    logic last;
    logic rlo0;
    logic rlo1;
    logic rhi0;
    logic rhi1;
    logic clo0;
    logic clo1;
    logic chi0;
    logic chi1;
  } meta_t;

  typedef struct packed {
    logic    valid;
    column_t col;
    meta_t   meta;
  } item_t;

  localparam coef_t LAWS_VEC [TAPS][TAPS] = '{
    '{ 4'sd1,  4'sd4, 4'sd6,  4'sd4,  4'sd1},
    '{-4'sd1, -4'sd2, 4'sd0,  4'sd2,  4'sd1},
    '{-4'sd1,  4'sd0, 4'sd2,  4'sd0, -4'sd1},
    '{-4'sd1,  4'sd2, 4'sd0, -4'sd2,  4'sd1},
    '{ 4'sd1, -4'sd4, 4'sd6, -4'sd4,  4'sd1}
  };

  // Undefined selector codes fall back to the level vector.
  function automatic coef_t law_coef(input vec_sel_t sel, input logic [2:0] k);
    vec_sel_t s;
    s = (sel > VEC_R5) ? VEC_L5 : sel;
    return LAWS_VEC[s][k];
  endfunction

  // Maps an unclamped tap (offset tap-2) to the tap that edge replication uses.
  function automatic logic [2:0] clamp_tap(input logic [2:0] t, input logic lo0,
                                           input logic lo1, input logic hi0,
                                           input logic hi1);
    logic [2:0] r;
    case (t)
      3'd0:    r = lo0 ? 3'd2 : (lo1 ? 3'd1 : 3'd0);
      3'd1:    r = lo0 ? 3'd2 : 3'd1;
      3'd3:    r = hi0 ? 3'd2 : 3'd3;
      3'd4:    r = hi0 ? 3'd2 : (hi1 ? 3'd3 : 3'd4);
      default: r = 3'd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] mul_coef(input sample_t s, input coef_t c);
    logic signed [15:0] a;
    logic signed [15:0] b;
    a = 16'(s);
    b = 16'(c);
    return a * b;
  endfunction

  function automatic hsum_t mul_wide(input vsum_t v, input coef_t c);
    hsum_t a;
    hsum_t b;
    a = HSUM_W'(v);
    b = HSUM_W'(c);
    return a * b;
  endfunction

endpackage
`default_nettype wire

@@ sv/lawtex_in_if.sv @@
// Input channel interface: one sample or drain item per transaction.
`default_nettype none
interface lawtex_in_if;
  import lawtex_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    drain;
  modport source(output valid, output sample, output drain, input ready);
  modport sink(input valid, input sample, input drain, output ready);
endinterface
`default_nettype wire

@@ sv/lawtex_out_if.sv @@
// Output channel interface: one mask response per transaction.
`default_nettype none
interface lawtex_out_if;
  import lawtex_pkg::*;
  logic  valid;
  logic  ready;
  resp_t response;
  logic  frame_last;
  modport source(output valid, output response, output frame_last, input ready);
  modport sink(input valid, input response, input frame_last, output ready);
endinterface
`default_nettype wire

@@ sv/lawtex_ram.sv @@
// Generic single-port RAM with read-first registered read.
`default_nettype none
module lawtex_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/lawtex_line_cell.sv @@
// One line-delay cell: stores a row of samples and hands the column on.
`default_nettype none
module lawtex_line_cell #(
  parameter int MAX_WIDTH = lawtex_pkg::MAX_WIDTH_DEF,
  parameter int IDX       = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] in_addr,
  input  wire lawtex_pkg::item_t            in_item,
  output logic      [$clog2(MAX_WIDTH)-1:0] out_addr,
  output lawtex_pkg::item_t                 out_item
);
  import lawtex_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  item_t          item_q;
  logic [AW-1:0]  addr_q;
  sample_t        rdata;

  // The sample in this cell's slot is written; the one a row older comes back.
  lawtex_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_ram (
    .clk  (clk),
    .en   (adv && in_item.valid),
    .we   (adv && in_item.valid),
    .addr (in_addr),
    .wdata(in_item.col[IDX]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q.valid <= 1'b0;
    end else if (adv) begin
      item_q <= in_item;
      addr_q <= in_addr;
    end
  end

  always_comb begin
    out_item           = item_q;
    out_item.col[IDX+1] = rdata;
    out_addr           = addr_q;
  end
endmodule
`default_nettype wire

@@ sv/laws_texture_mask_convolution.sv @@
// Top level of the 5x5 Laws texture mask filter over a raster sample stream.
//
// The filter takes one mean-subtracted 12-bit sample per transaction in raster
// order and returns the 5x5 Laws mask response of each pixel, with edge rows
// and columns replicated. The pipeline runs at one transaction per clock and
// holds only when a finished response is not taken. The real sample with
// raster index k yields the response of pixel k-(2W+2); after the last real
// sample of a frame, each drain transaction yields one more response, and the
// final pixel carries frame_last, after which a new frame starts. A drain
// before the last real sample is accepted and dropped; a sample after it acts
// as a drain. Any configuration write restarts the frame. The path from an
// accepted transaction to its response register has seven register stages:
// four line-delay cells, each a single-port RAM of MAX_WIDTH words accessed
// once per transaction, then the window register, the vertical sum and the
// horizontal sum. The line RAMs need no clearing pass after reset; rows above
// and below the image are never read unclamped.
`default_nettype none
module laws_texture_mask_convolution #(
  parameter int MAX_WIDTH = lawtex_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire lawtex_pkg::cfg_idx_t         cfg_index,
  input  wire logic [lawtex_pkg::CFG_W-1:0] cfg_data,
  lawtex_in_if.sink                         in_ch,
  lawtex_out_if.source                      out_ch
);
  import lawtex_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  // Configuration registers.
  vec_sel_t         vsel;
  vec_sel_t         hsel;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  // Effective image size after clamping to the supported range.
  logic [CW-1:0]    w_eff;
  logic [HGT_W-1:0] h_eff;

  // Position of the next processed transaction and of the next output pixel.
  logic [AW-1:0]     kcol;
  logic [KROW_W-1:0] krow;
  logic [AW-1:0]     out_col;
  logic [ROW_W-1:0]  out_row;

  logic  adv;
  logic  accept;
  logic  process;
  logic  primed;
  meta_t meta0;
  item_t chain [LINE_CELLS+1];
  logic [AW-1:0] addr_chain [LINE_CELLS];

  column_t win [TAPS];
  meta_t   win_meta;
  logic    win_valid;

  vsum_t v_next [TAPS];
  vsum_t vsum [TAPS];
  meta_t v_meta;
  logic  v_valid;

  hsum_t resp_next;
  logic  out_valid;

  always_comb begin
    if (width_reg < CFG_W'(3)) begin
      w_eff = CW'(3);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_reg);
    end
    if (height_reg < CFG_W'(3)) begin
      h_eff = HGT_W'(3);
    end else if (32'(height_reg) > MAX_HEIGHT) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = HGT_W'(height_reg);
    end
  end

  // The whole pipeline moves together; it holds only while a response waits.
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  // A drain before the last real sample does nothing.
  assign process = !(in_ch.drain && (KROW_W'(h_eff) > krow));
  // Outputs start once 2W+2 transactions have gone in.
  assign primed  = (krow > KROW_W'(2)) || ((krow == KROW_W'(2)) && (kcol >= AW'(2)));

  always_comb begin
    meta0.emit = primed;
    meta0.rlo0 = (out_row == ROW_W'(0));
    meta0.rlo1 = (out_row == ROW_W'(1));
    meta0.rhi0 = (HGT_W'(out_row) == h_eff - HGT_W'(1));
    meta0.rhi1 = (HGT_W'(out_row) == h_eff - HGT_W'(2));
    meta0.clo0 = (out_col == AW'(0));
    meta0.clo1 = (out_col == AW'(1));
    meta0.chi0 = (CW'(out_col) == w_eff - CW'(1));
    meta0.chi1 = (CW'(out_col) == w_eff - CW'(2));
    meta0.last = meta0.rhi0 && meta0.chi0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vsel       <= VEC_L5;
      hsel       <= VEC_L5;
      width_reg  <= DIM_RESET;
      height_reg <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VSEL:   vsel       <= cfg_data[SEL_W-1:0];
        CFG_HSEL:   hsel       <= cfg_data[SEL_W-1:0];
        CFG_WIDTH:  width_reg  <= cfg_data;
        CFG_HEIGHT: height_reg <= cfg_data;
        default:    vsel       <= vsel;
      endcase
    end
  end

  // Stream position counters; a configuration write or the final pixel of a
  // frame returns them all to the origin.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      kcol    <= '0;
      krow    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept && process) begin
      if (primed && meta0.last) begin
        kcol    <= '0;
        krow    <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (CW'(kcol) == w_eff - CW'(1)) begin
          kcol <= '0;
          krow <= krow + KROW_W'(1);
        end else begin
          kcol <= kcol + AW'(1);
        end
        if (primed) begin
          if (meta0.chi0) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + AW'(1);
          end
        end
      end
    end
  end

  // The newest sample enters the column; the line cells fill in the four
  // older rows at the same column, one per stage.
  always_comb begin
    chain[0].valid  = accept && process;
    chain[0].col    = '0;
    chain[0].col[0] = in_ch.sample;
    chain[0].meta   = meta0;
    addr_chain[0]   = kcol;
  end

  for (genvar g = 0; g < LINE_CELLS; g++) begin : g_line
    if (g < LINE_CELLS - 1) begin : g_mid
      lawtex_line_cell #(.MAX_WIDTH(MAX_WIDTH), .IDX(g)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .adv     (adv),
        .in_addr (addr_chain[g]),
        .in_item (chain[g]),
        .out_addr(addr_chain[g+1]),
        .out_item(chain[g+1])
      );
    end else begin : g_end
      lawtex_line_cell #(.MAX_WIDTH(MAX_WIDTH), .IDX(g)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .adv     (adv),
        .in_addr (addr_chain[g]),
        .in_item (chain[g]),
        .out_addr(),
        .out_item(chain[g+1])
      );
    end
  end

  // The window shifts left by one column per processed transaction. The
  // newest column sits at position four and belongs to two columns right of
  // the pixel; positions that fall outside the image are replaced by
  // replication when the sums are formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (adv) begin
      win_valid <= chain[LINE_CELLS].valid && chain[LINE_CELLS].meta.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && chain[LINE_CELLS].valid) begin
      for (int p = 0; p < TAPS - 1; p++) begin
        win[p] <= win[p+1];
      end
      win[TAPS-1] <= chain[LINE_CELLS].col;
      win_meta    <= chain[LINE_CELLS].meta;
    end
  end

  // Vertical pass: each window column is weighted by the vertical vector,
  // with rows above and below the image replaced by the edge row.
  always_comb begin
    logic [2:0] e;
    vsum_t      acc;
    for (int p = 0; p < TAPS; p++) begin
      acc = '0;
      for (int i = 0; i < TAPS; i++) begin
        e   = 3'(TAPS - 1) - clamp_tap(3'(i), win_meta.rlo0, win_meta.rlo1,
                                       win_meta.rhi0, win_meta.rhi1);
        acc = acc + VSUM_W'(mul_coef(win[p][e], law_coef(vsel, 3'(i))));
      end
      v_next[p] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
    end else if (adv) begin
      v_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vsum   <= v_next;
      v_meta <= win_meta;
    end
  end

  // Horizontal pass over the column sums, with replicated edge columns.
  always_comb begin
    hsum_t acc;
    acc = '0;
    for (int j = 0; j < TAPS; j++) begin
      acc = acc + mul_wide(vsum[clamp_tap(3'(j), v_meta.clo0, v_meta.clo1,
                                          v_meta.chi0, v_meta.chi1)],
                           law_coef(hsel, 3'(j)));
    end
    resp_next = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.response   <= resp_next[RESP_W-1:0];
      out_ch.frame_last <= v_meta.last;
    end
  end

  assign out_ch.valid = out_valid;

  // The line address always stays inside the current row.
  a_kcol_in_row: assert property (@(posedge clk) disable iff (rst)
    CW'(kcol) < w_eff)
    else $error("line address beyond image width");

  // The row counter stays within two rows past the last real row of a frame.
  a_krow_bound: assert property (@(posedge clk) disable iff (rst)
    krow <= KROW_W'(h_eff) + KROW_W'(2))
    else $error("row counter ran past the drain rows");

  // A configuration write restarts the frame at the origin.
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (kcol == '0 && krow == '0 && out_col == '0 && out_row == '0))
    else $error("frame not restarted after configuration write");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the Laws 5x5 texture mask filter.
`timescale 1ns / 1ps
module testbench;
  import lawtex_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lawtex_in_if  in_ch ();
  lawtex_out_if out_ch ();

  laws_texture_mask_convolution u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // One pixel transaction waiting to be driven: a sample or a drain marker.
  typedef struct {
    sample_t sample;
    logic    drain;
  } pixel_txn_t;

  // One response the filter is expected to return.
  typedef struct {
    resp_t response;
    logic  frame_last;
  } mask_result_t;

  localparam int HISTORY_DEPTH = 4 * 1024 + 8;

  pixel_txn_t   pixel_queue[$];
  mask_result_t response_queue[$];
  int           mismatch_count;
  int           items_sent;
  bit           quiet_tail;
  bit           in_fire;
  int           send_gap;
  int           sink_stall;

  // Our own copy of the filter state and registers.
  int          sample_history[HISTORY_DEPTH];
  logic [2:0]  vsel_reg;
  logic [2:0]  hsel_reg;
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  int unsigned next_in_col, next_in_row, next_out_col, next_out_row;

  // Laws vectors: level, edge, spot, wave, ripple.
  int laws_taps[5][5] = '{
    '{ 1,  4, 6,  4,  1},
    '{-1, -2, 0,  2,  1},
    '{-1,  0, 2,  0, -1},
    '{-1,  2, 0, -2,  1},
    '{ 1, -4, 6, -4,  1}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_dim(input int unsigned v);
    return (v < 3) ? 3 : ((v > 1024) ? 1024 : v);
  endfunction

  // Selector codes above the ripple vector fall back to the level vector.
  function automatic int fix_sel(input logic [2:0] s);
    return (s > VEC_R5) ? 0 : int'(s);
  endfunction

  // Exact 5x5 sum around (r, c) with the image edges replicated.
  function automatic int laws_sum(input int unsigned r, input int unsigned c,
                                  input int unsigned w, input int unsigned h);
    int acc;
    int rr;
    int cc;
    int vs;
    int hs;
    acc = 0;
    vs = fix_sel(vsel_reg);
    hs = fix_sel(hsel_reg);
    for (int i = 0; i < 5; i++) begin
      rr = int'(r) + i - 2;
      if (rr < 0) rr = 0;
      if (rr > int'(h) - 1) rr = int'(h) - 1;
      for (int j = 0; j < 5; j++) begin
        cc = int'(c) + j - 2;
        if (cc < 0) cc = 0;
        if (cc > int'(w) - 1) cc = int'(w) - 1;
        acc += laws_taps[vs][i] * laws_taps[hs][j] *
               sample_history[(rr * int'(w) + cc) % HISTORY_DEPTH];
      end
    end
    return acc;
  endfunction

  // Advances the predicted state by one accepted transaction and queues the
  // response it produces, if any.
  function automatic void predict_pixel(input sample_t s, input logic drn);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned lag;
    int unsigned in_lin;
    int unsigned out_lin;
    bit emit;
    mask_result_t res;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    total = w * h;
    lag = 2 * w + 2;
    in_lin = next_in_row * w + next_in_col;
    out_lin = next_out_row * w + next_out_col;
    emit = 1'b0;
    if (!drn && in_lin < total) begin
      sample_history[in_lin % HISTORY_DEPTH] = int'(s);
      emit = (in_lin >= lag);
      next_in_col++;
      if (next_in_col >= w) begin
        next_in_col = 0;
        next_in_row++;
      end
    end else if (in_lin >= total) begin
      emit = 1'b1;
    end
    if (emit) begin
      res.response = resp_t'(laws_sum(next_out_row, next_out_col, w, h));
      res.frame_last = (out_lin + 1 >= total);
      response_queue.push_back(res);
      if (res.frame_last) begin
        next_in_col = 0; next_in_row = 0; next_out_col = 0; next_out_row = 0;
      end else begin
        next_out_col++;
        if (next_out_col >= w) begin
          next_out_col = 0;
          next_out_row++;
        end
      end
    end
  endfunction

  // Input driver: pops a pending transaction once the previous one is taken,
  // and inserts random gaps between transactions.
  always @(negedge clk) begin
    if (!rst && (!in_ch.valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_ch.sample <= pixel_queue[0].sample;
        in_ch.drain <= pixel_queue[0].drain;
        in_ch.valid <= 1'b1;
        void'(pixel_queue.pop_front());
        if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 9);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure in random bursts.
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) sink_stall <= $urandom_range(1, 9);
      end
    end
  end

  // Monitor: predicts on every accepted input and checks every accepted output.
  always @(posedge clk) begin
    mask_result_t exp_res;
    in_fire = !rst && in_ch.valid && in_ch.ready;
    if (in_fire) predict_pixel(in_ch.sample, in_ch.drain);
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (response_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected response %0d", out_ch.response));
      end else begin
        exp_res = response_queue.pop_front();
        if (out_ch.response !== exp_res.response)
          report_mismatch($sformatf("response %0d, expected %0d",
                                    out_ch.response, exp_res.response));
        if (out_ch.frame_last !== exp_res.frame_last)
          report_mismatch($sformatf("frame_last %b, expected %b",
                                    out_ch.frame_last, exp_res.frame_last));
      end
    end
  end

  task automatic queue_pixel(input sample_t s, input logic drn);
    pixel_txn_t t;
    t.sample = s;
    t.drain = drn;
    pixel_queue.push_back(t);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'(-2048);
      1: return sample_t'(2047);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Waits until the filter has nothing left to do, then lets its pipeline
  // empty out, since ignored transactions produce no response to wait for.
  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_ch.valid || response_queue.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write; the predictor sees it at the same edge as the filter.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_VSEL:   vsel_reg = value[2:0];
      CFG_HSEL:   hsel_reg = value[2:0];
      CFG_WIDTH:  width_reg = value;
      CFG_HEIGHT: height_reg = value;
      default: ;
    endcase
    next_in_col = 0; next_in_row = 0; next_out_col = 0; next_out_row = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int vs, input int hs, input int w, input int h);
    wait_idle();
    write_reg(CFG_VSEL, CFG_W'(vs));
    write_reg(CFG_HSEL, CFG_W'(hs));
    write_reg(CFG_WIDTH, CFG_W'(w));
    write_reg(CFG_HEIGHT, CFG_W'(h));
  endtask

  // One frame of w*h samples and its drains. Early drains land before the
  // last sample and are dropped; surplus samples stand in for some drains.
  task automatic send_frame(input int w, input int h, input bit noisy);
    int n;
    n = clamp_dim(w) * clamp_dim(h);
    for (int k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 15) == 0) queue_pixel(rand_sample(), 1'b1);
      queue_pixel(rand_sample(), 1'b0);
      items_sent++;
    end
    for (int k = 0; k < 2 * clamp_dim(w) + 2; k++) begin
      queue_pixel(rand_sample(), !(noisy && $urandom_range(0, 3) == 0));
      items_sent++;
    end
  endtask

  initial begin
    int w;
    int h;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_VSEL;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.drain = 1'b0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    quiet_tail = 1'b0;
    in_fire = 1'b0;
    send_gap = 0;
    sink_stall = 0;
    vsel_reg = VEC_L5;
    hsel_reg = VEC_L5;
    width_reg = DIM_RESET;
    height_reg = DIM_RESET;
    next_in_col = 0; next_in_row = 0; next_out_col = 0; next_out_row = 0;
    foreach (sample_history[i]) sample_history[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Smallest frame: extreme samples, an early drain that must be dropped,
    // and a surplus sample that acts as a drain.
    configure(VEC_E5, VEC_R5, 3, 3);
    queue_pixel(sample_t'(2047), 1'b0);
    queue_pixel(sample_t'(0), 1'b1);
    queue_pixel(sample_t'(-2048), 1'b0);
    for (int k = 0; k < 7; k++) queue_pixel(k[0] ? sample_t'(2047) : sample_t'(-2048), 1'b0);
    queue_pixel(sample_t'(-2048), 1'b0);
    for (int k = 0; k < 7; k++) queue_pixel(sample_t'(5), 1'b1);
    items_sent += 17;

    // Every vector on both axes, selector codes above ripple, and
    // out-of-range dimensions that clamp to the minimum.
    for (int s = 0; s < 8; s++) begin
      configure(s, 7 - s, (s == 0) ? 0 : 4, (s == 1) ? 1 : 3);
      send_frame((s == 0) ? 0 : 4, (s == 1) ? 1 : 3, 1'b0);
    end

    // A frame cut short by a register write.
    configure(VEC_S5, VEC_W5, 6, 5);
    for (int k = 0; k < 20; k++) queue_pixel(rand_sample(), 1'b0);
    items_sent += 20;

    // Widest and tallest sizes, including a width above the limit; each of
    // these frames is cut short by the next register write.
    configure(VEC_W5, VEC_E5, 2047, 0);
    for (int k = 0; k < 60; k++) queue_pixel(rand_sample(), 1'b0);
    items_sent += 60;
    configure(VEC_R5, VEC_S5, 1, 1024);
    for (int k = 0; k < 200; k++) queue_pixel(rand_sample(), 1'b0);
    items_sent += 200;

    // Random small frames with random content, some noisy, some aborted.
    while (items_sent < 1350) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 10);
      h = $urandom_range(3, 7);
      if (items_sent > 1100) quiet_tail = 1'b1;
      configure($urandom_range(0, 7), $urandom_range(0, 7), w, h);
      repeat ($urandom_range(1, 3)) send_frame(w, h, $urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) == 0) begin
        for (int k = 0; k < $urandom_range(1, w * h); k++) begin
          queue_pixel(rand_sample(), 1'b0);
          items_sent++;
        end
      end
    end

    while (pixel_queue.size() > 0 || in_ch.valid || response_queue.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ laws_texture_mask_convolution.f @@
sv/lawtex_pkg.sv
sv/lawtex_in_if.sv
sv/lawtex_out_if.sv
sv/lawtex_ram.sv
sv/lawtex_line_cell.sv
sv/laws_texture_mask_convolution.sv
sim/testbench.sv
